// ----- hdl/ste_pkg.sv -----
// ----------------------------------------------------------------------------
// ste_pkg
// Shared constants, codes and types for the semaphore table engine.
// ----------------------------------------------------------------------------
package ste_pkg;

  localparam int NUM_SEMS    = 256;
  localparam int QUEUE_DEPTH = 32;
  localparam int PID_BITS    = 16;

  localparam int TYPE_W  = 3;
  localparam int KEY_W   = 8;
  localparam int CNT_W   = 16;
  localparam int FPID_W  = 16;
  localparam int STAT_W  = 2;
  localparam int SEM_W   = $clog2(NUM_SEMS);
  localparam int QD_W    = $clog2(QUEUE_DEPTH);
  localparam int WCNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STA_W   = SEM_W + QD_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [TYPE_W-1:0] {
    REQ_CREATE  = 3'd0,
    REQ_WAIT    = 3'd1,
    REQ_SIGNAL  = 3'd2,
    REQ_RDCOUNT = 3'd3,
    REQ_SETCNT  = 3'd4,
    REQ_RDWAIT  = 3'd5,
    REQ_DELETE  = 3'd6
  } req_code_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_ERR     = 2'd1,
    ST_BLOCKED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_FAIL,
    S_CREATE,
    S_EXEC,
    S_POP
  } state_t;

  // per-semaphore record kept in table memory
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [WCNT_W-1:0] wcnt;
    logic [QD_W-1:0]   head;
  } meta_t;

  // sequencer to memory controls
  typedef struct packed {
    logic                meta_re;
    logic                meta_we;
    logic [SEM_W-1:0]    meta_addr;
    meta_t               meta_wdata;
    logic                st_re;
    logic                st_we;
    logic [STA_W-1:0]    st_addr;
    logic [PID_BITS-1:0] st_wdata;
  } mem_ctl_t;

endpackage

// ----- hdl/ste_req_if.sv -----
// ----------------------------------------------------------------------------
// ste_req_if / ste_rsp_if
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ste_req_if;
  logic                        valid;
  logic                        ready;
  logic [ste_pkg::TYPE_W-1:0]  req_type;
  logic [ste_pkg::KEY_W-1:0]   sem_key;
  logic                        create_any;
  logic [ste_pkg::FPID_W-1:0]  caller_pid;
  logic [ste_pkg::CNT_W-1:0]   new_count;

  modport source (output valid, req_type, sem_key, create_any, caller_pid, new_count,
                  input ready);
  modport sink   (input valid, req_type, sem_key, create_any, caller_pid, new_count,
                  output ready);
endinterface

interface ste_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ste_pkg::STAT_W-1:0]  status;
  logic [ste_pkg::KEY_W-1:0]   key_out;
  logic [ste_pkg::CNT_W-1:0]   read_data;
  logic                        woken_valid;
  logic [ste_pkg::FPID_W-1:0]  woken_pid;
  logic                        last;

  modport source (output valid, status, key_out, read_data, woken_valid, woken_pid, last,
                  input ready);
  modport sink   (input valid, status, key_out, read_data, woken_valid, woken_pid, last,
                  output ready);
endinterface

// ----- hdl/semaphore_table_engine_top.sv -----
// ----------------------------------------------------------------------------
// semaphore_table_engine_top
// Counting semaphore table with per-key FIFO wait queues.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  --------+-----+-------------------------------------------------------
//  req     | in  | req_type, sem_key, create_any, caller_pid, new_count
//  rsp     | out | status, key_out, read_data, woken_valid, woken_pid, last
//
//  One request at a time; ready only while the sequencer is idle.
//  Keyed requests step through accept, check with record read and execute,
//  plus a pop step on signal with waiters. Create-any first scans the used
//  keys in order (up to NUM_SEMS). Delete adds one pop step per waiter.
//  Reset clears the allocated marks; records are rewritten at create.
//  A result waits in the output register; the sequencer stalls on it.
// ----------------------------------------------------------------------------
module semaphore_table_engine_top (
  input logic          clk,
  input logic          rst,
  ste_req_if.sink      req,
  ste_rsp_if.source    rsp
);

  ste_pkg::state_t state, state_next;

  // latched request
  logic [ste_pkg::TYPE_W-1:0]  r_type;
  logic [ste_pkg::KEY_W-1:0]   r_key;
  logic                        r_any;
  logic [ste_pkg::PID_BITS-1:0] r_pid;
  logic [ste_pkg::CNT_W-1:0]   r_newc;

  // free-key scan pointer
  logic [ste_pkg::SEM_W-1:0]   scan_idx;

  // working copy of the record during the pop loop
  logic [ste_pkg::CNT_W-1:0]   w_cnt;
  logic [ste_pkg::WCNT_W-1:0]  w_wc;
  logic [ste_pkg::QD_W-1:0]    w_head;

  logic [ste_pkg::NUM_SEMS-1:0] used;

  ste_pkg::mem_ctl_t            ctl;
  ste_pkg::meta_t               meta_rd;
  logic [ste_pkg::PID_BITS-1:0] st_rd;

  ste_store u_store (
    .clk        (clk),
    .ctl        (ctl),
    .meta_rdata (meta_rd),
    .st_rdata   (st_rd)
  );

  logic [ste_pkg::SEM_W-1:0] kidx;
  logic key_ok, key_used, emit_ok, accept;
  assign kidx     = r_key[ste_pkg::SEM_W-1:0];
  assign key_ok   = ({1'b0, r_key} < (ste_pkg::KEY_W+1)'(ste_pkg::NUM_SEMS));
  assign key_used = used[kidx];
  assign emit_ok  = !rsp.valid || rsp.ready;
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == ste_pkg::S_IDLE);

  // next head and queue tail
  logic [ste_pkg::QD_W-1:0] head_inc, tail;
  logic [ste_pkg::QD_W:0]   tail_sum;
  logic [ste_pkg::WCNT_W-1:0] wc_dec;
  assign head_inc = (w_head == ste_pkg::QD_W'(ste_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : w_head + 1'b1;
  assign tail_sum = (ste_pkg::QD_W+1)'(meta_rd.head) + (ste_pkg::QD_W+1)'(meta_rd.wcnt);
  assign tail     = (tail_sum >= (ste_pkg::QD_W+1)'(ste_pkg::QUEUE_DEPTH)) ?
                    ste_pkg::QD_W'(tail_sum - (ste_pkg::QD_W+1)'(ste_pkg::QUEUE_DEPTH)) :
                    tail_sum[ste_pkg::QD_W-1:0];
  assign wc_dec   = w_wc - 1'b1;

  logic q_full;
  assign q_full = (meta_rd.wcnt >= ste_pkg::WCNT_W'(ste_pkg::QUEUE_DEPTH));

  // ---- next state ----
  always_comb begin
    state_next = state;
    unique case (state)
      ste_pkg::S_IDLE: begin
        if (accept) begin
          if ((req.req_type == ste_pkg::REQ_CREATE) && req.create_any) begin
            state_next = ste_pkg::S_SCAN;
          end else begin
            state_next = ste_pkg::S_CHECK;
          end
        end
      end
      ste_pkg::S_SCAN: begin
        if (!used[scan_idx]) begin
          state_next = ste_pkg::S_CREATE;
        end else if (scan_idx == ste_pkg::SEM_W'(ste_pkg::NUM_SEMS - 1)) begin
          state_next = ste_pkg::S_FAIL;
        end
      end
      ste_pkg::S_CHECK: begin
        if (!key_ok) begin
          state_next = ste_pkg::S_FAIL;
        end else if (r_type == ste_pkg::REQ_CREATE) begin
          state_next = key_used ? ste_pkg::S_FAIL : ste_pkg::S_CREATE;
        end else if (!key_used || r_type > ste_pkg::REQ_DELETE) begin
          state_next = ste_pkg::S_FAIL;
        end else begin
          state_next = ste_pkg::S_EXEC;
        end
      end
      ste_pkg::S_FAIL, ste_pkg::S_CREATE: begin
        if (emit_ok) state_next = ste_pkg::S_IDLE;
      end
      ste_pkg::S_EXEC: begin
        if ((r_type == ste_pkg::REQ_SIGNAL || r_type == ste_pkg::REQ_DELETE) &&
            meta_rd.wcnt != '0) begin
          state_next = ste_pkg::S_POP;
        end else if (emit_ok) begin
          state_next = ste_pkg::S_IDLE;
        end
      end
      ste_pkg::S_POP: begin
        if (emit_ok && (r_type == ste_pkg::REQ_SIGNAL || wc_dec == '0)) begin
          state_next = ste_pkg::S_IDLE;
        end
      end
      default: state_next = ste_pkg::S_IDLE;
    endcase
  end

  // ---- outputs: result, memory controls, table updates ----
  logic                          emit;
  ste_pkg::status_t              e_status;
  logic [ste_pkg::KEY_W-1:0]     e_key;
  logic [ste_pkg::CNT_W-1:0]     e_rd;
  logic                          e_wv;
  logic [ste_pkg::FPID_W-1:0]    e_wpid;
  logic                          e_last;
  logic                          used_set, used_clr, load_work, pop_step;

  always_comb begin
    emit      = 1'b0;
    e_status  = ste_pkg::ST_OK;
    e_key     = '0;
    e_rd      = '0;
    e_wv      = 1'b0;
    e_wpid    = '0;
    e_last    = 1'b1;
    used_set  = 1'b0;
    used_clr  = 1'b0;
    load_work = 1'b0;
    pop_step  = 1'b0;
    ctl            = '0;
    ctl.meta_addr  = kidx;
    ctl.meta_wdata = meta_rd;
    ctl.st_addr    = {kidx, meta_rd.head};
    ctl.st_wdata   = r_pid;
    unique case (state)
      ste_pkg::S_CHECK: begin
        ctl.meta_re = 1'b1;
      end
      ste_pkg::S_FAIL: begin
        emit     = emit_ok;
        e_status = ste_pkg::ST_ERR;
      end
      ste_pkg::S_CREATE: begin
        emit     = emit_ok;
        e_key    = r_key;
        used_set = emit_ok;
        ctl.meta_we    = emit_ok;
        ctl.meta_wdata = '{count: ste_pkg::CNT_W'(1), wcnt: '0, head: '0};
      end
      ste_pkg::S_EXEC: begin
        case (r_type)
          ste_pkg::REQ_WAIT: begin
            emit = emit_ok;
            if (meta_rd.count != '0) begin
              ctl.meta_we = emit_ok;
              ctl.meta_wdata.count = meta_rd.count - 1'b1;
            end else if (q_full) begin
              e_status = ste_pkg::ST_FULL;
            end else begin
              e_status = ste_pkg::ST_BLOCKED;
              ctl.meta_we = emit_ok;
              ctl.meta_wdata.wcnt = meta_rd.wcnt + 1'b1;
              ctl.st_we   = emit_ok;
              ctl.st_addr = {kidx, tail};
            end
          end
          ste_pkg::REQ_SIGNAL, ste_pkg::REQ_DELETE: begin
            if (meta_rd.wcnt != '0) begin
              ctl.st_re = 1'b1;
              load_work = 1'b1;
            end else begin
              emit = emit_ok;
              if (r_type == ste_pkg::REQ_DELETE) begin
                used_clr = emit_ok;
              end else if (meta_rd.count != ste_pkg::COUNT_MAX) begin
                ctl.meta_we = emit_ok;
                ctl.meta_wdata.count = meta_rd.count + 1'b1;
              end
            end
          end
          ste_pkg::REQ_RDCOUNT: begin
            emit = emit_ok;
            e_rd = meta_rd.count;
          end
          ste_pkg::REQ_SETCNT: begin
            emit = emit_ok;
            ctl.meta_we = emit_ok;
            ctl.meta_wdata.count = r_newc;
          end
          ste_pkg::REQ_RDWAIT: begin
            emit = emit_ok;
            e_rd = ste_pkg::CNT_W'(meta_rd.wcnt);
          end
          default: begin
            emit = emit_ok;
            e_status = ste_pkg::ST_ERR;
          end
        endcase
      end
      ste_pkg::S_POP: begin
        emit     = emit_ok;
        e_wv     = 1'b1;
        e_wpid   = ste_pkg::FPID_W'(st_rd);
        pop_step = emit_ok;
        if (r_type == ste_pkg::REQ_SIGNAL) begin
          ctl.meta_we    = emit_ok;
          ctl.meta_wdata = '{count: w_cnt, wcnt: wc_dec, head: head_inc};
        end else begin
          e_last   = (wc_dec == '0);
          used_clr = emit_ok && (wc_dec == '0);
          ctl.st_re   = emit_ok && (wc_dec != '0);
          ctl.st_addr = {kidx, head_inc};
        end
      end
      default: ;
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ste_pkg::S_IDLE;
      used      <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (used_set) used[kidx] <= 1'b1;
      if (used_clr) used[kidx] <= 1'b0;
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_type   <= req.req_type;
      r_key    <= req.sem_key;
      r_any    <= req.create_any;
      r_pid    <= ste_pkg::PID_BITS'(req.caller_pid);
      r_newc   <= req.new_count;
      scan_idx <= '0;
    end else if (state == ste_pkg::S_SCAN) begin
      if (!used[scan_idx] && r_any) begin
        r_key <= ste_pkg::KEY_W'(scan_idx);
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
    if (load_work) begin
      w_cnt  <= meta_rd.count;
      w_wc   <= meta_rd.wcnt;
      w_head <= meta_rd.head;
    end else if (pop_step) begin
      w_wc   <= wc_dec;
      w_head <= head_inc;
    end
    if (emit) begin
      rsp.status      <= e_status;
      rsp.key_out     <= e_key;
      rsp.read_data   <= e_rd;
      rsp.woken_valid <= e_wv;
      rsp.woken_pid   <= e_wpid;
      rsp.last        <= e_last;
    end
  end

endmodule

// ----- hdl/ste_store.sv -----
// ----------------------------------------------------------------------------
// ste_store
// Semaphore record table and waiter queue memories, registered reads.
// ----------------------------------------------------------------------------
module ste_store (
  input  logic                         clk,
  input  ste_pkg::mem_ctl_t            ctl,
  output ste_pkg::meta_t               meta_rdata,
  output logic [ste_pkg::PID_BITS-1:0] st_rdata
);

  ste_pkg::meta_t               meta_mem [ste_pkg::NUM_SEMS];
  logic [ste_pkg::PID_BITS-1:0] wait_mem [2**ste_pkg::STA_W];

  always_ff @(posedge clk) begin
    if (ctl.meta_we) begin
      meta_mem[ctl.meta_addr] <= ctl.meta_wdata;
    end
    if (ctl.meta_re) begin
      meta_rdata <= meta_mem[ctl.meta_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.st_we) begin
      wait_mem[ctl.st_addr] <= ctl.st_wdata;
    end
    if (ctl.st_re) begin
      st_rdata <= wait_mem[ctl.st_addr];
    end
  end

endmodule
